[hw/rtl/stq_pkg.sv]
// ----------------------------------------------------------------------------
// stq_pkg: shared types and constants of the sorted timer queue
// Holds slot and time widths, command and result codes, and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package stq_pkg;

   localparam int NumSlots = 16;
   localparam int SlotBits = 4;
   localparam int LinkBits = SlotBits + 1;
   localparam int TimeBits = 32;
   localparam int TagBits  = 32;
   localparam int MaxRes   = 16;
   localparam int ResBits  = 5;

   // null marker is the top bit set
   localparam logic [LinkBits-1:0] LinkNil = {1'b1, {SlotBits{1'b0}}};

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_ADJUST = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_TICK   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_ACK     = 2'd0,
      KIND_EXPIRED = 2'd1,
      KIND_NONE    = 2'd2,
      KIND_RSVD    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_BUSY   = 2'd1,
      STAT_IDLE   = 2'd2,
      STAT_RSVD   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_UNLINK,
      ST_SCAN,
      ST_LINK,
      ST_TICK_CHK,
      ST_TICK_POP,
      ST_RESP,
      ST_WAIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture input word
      logic unlink;     // unlink captured slot
      logic set_active; // mark slot active
      logic clr_active; // mark slot idle
      logic write_exp;  // store expiry (the tag is stored with set_active)
      logic scan_start; // cursor to head
      logic scan_step;  // cursor advance
      logic link;       // link slot before cursor
      logic pop_head;   // unlink head, capture it as result
      logic resp_ack;   // build acknowledge result
      logic resp_none;  // build empty tick result
      logic resp_exp;   // build expired result
      status_type stat;
      logic res_last;
   } stq_cmd_type;

   // datapath to controller
   typedef struct packed {
      cmd_type cmd;
      logic    in_range;
      logic    busy;
      logic    scan_more;  // cursor valid and its time <= new time
      logic    head_due;   // head valid and its time <= now
      logic    next_due;   // entry after the head valid and its time <= now
   } stq_stat_type;

endpackage

[hw/rtl/stq_ctrl.sv]
// ----------------------------------------------------------------------------
// stq_ctrl: command sequencer of the sorted timer queue
// Walks each command through unlink, sorted scan, link and tick pops,
// and hands result words to the output register.
// ----------------------------------------------------------------------------
module stq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  stq_pkg::stq_stat_type sts,
   output stq_pkg::stq_cmd_type  cmd
);
   import stq_pkg::*;

   state_type state_ff, state_in;
   logic [ResBits-1:0] cnt_ff, cnt_in;
   logic vld_ff, vld_in;
   logic [SlotBits-1:0] guard_ff, guard_in;
   logic guard_end_ff, guard_end_in;
   status_type stat_ff, stat_in;
   logic last_ff, last_in;

   assign rsp_tvalid = vld_ff;
   assign req_tready = (state_ff == ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_tvalid) state_in = ST_DECODE;
         ST_DECODE: begin
            if (sts.cmd == CMD_TICK) state_in = ST_TICK_CHK;
            else if (!sts.in_range) state_in = ST_RESP;
            else if (sts.cmd == CMD_ADD)
               state_in = sts.busy ? ST_RESP : ST_SCAN;
            else state_in = sts.busy ? ST_UNLINK : ST_RESP;
         end
         ST_UNLINK: state_in = (sts.cmd == CMD_ADJUST) ? ST_SCAN : ST_RESP;
         ST_SCAN: if (!sts.scan_more || guard_end_ff) state_in = ST_LINK;
         ST_LINK: state_in = ST_RESP;
         ST_TICK_CHK: state_in = sts.head_due ? ST_TICK_POP : ST_RESP;
         ST_TICK_POP: state_in = ST_WAIT;
         ST_RESP: state_in = ST_WAIT;
         ST_WAIT: begin
            if (!vld_ff || rsp_tready) begin
               if (sts.cmd == CMD_TICK && !last_ff) state_in = ST_TICK_CHK;
               else state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      cmd.stat = STAT_OK;
      cmd.load = (state_ff == ST_IDLE) && req_tvalid;
      unique case (state_ff)
         ST_DECODE: if (sts.cmd != CMD_TICK) begin
            cmd.scan_start = 1'b1;
            if (sts.in_range && sts.cmd == CMD_ADD && !sts.busy) begin
               cmd.set_active = 1'b1;
               cmd.write_exp  = 1'b1;
            end
         end
         ST_UNLINK: begin
            cmd.unlink = 1'b1;
            if (sts.cmd == CMD_ADJUST) cmd.write_exp = 1'b1;
            else cmd.clr_active = 1'b1;
         end
         ST_SCAN: begin
            cmd.scan_step = sts.scan_more && !guard_end_ff;
         end
         ST_LINK: cmd.link = 1'b1;
         ST_TICK_POP: begin
            cmd.pop_head = 1'b1;
            cmd.resp_exp = 1'b1;
            // last when the next entry is not due or the cap is reached
            cmd.res_last = !(sts.next_due && cnt_ff != ResBits'(MaxRes - 1));
         end
         ST_RESP: begin
            cmd.res_last = 1'b1;
            if (sts.cmd == CMD_TICK) cmd.resp_none = 1'b1;
            else begin
               cmd.resp_ack = 1'b1;
               cmd.stat = stat_ff;
            end
         end
         default: ;
      endcase
   end

   // counters, decoded status and result valid
   always_comb begin
      cnt_in = cnt_ff;
      guard_in = guard_ff;
      guard_end_in = guard_end_ff;
      stat_in = stat_ff;
      last_in = last_ff;
      vld_in = vld_ff;
      if (vld_ff && rsp_tready) vld_in = 1'b0;
      if (state_ff == ST_IDLE) cnt_in = '0;
      if (state_ff == ST_DECODE) begin
         guard_in = '0;
         guard_end_in = 1'b0;
         // status as seen before the command changes the slot
         if (!sts.in_range) stat_in = STAT_IDLE;
         else if (sts.cmd == CMD_ADD) stat_in = sts.busy ? STAT_BUSY : STAT_OK;
         else stat_in = sts.busy ? STAT_OK : STAT_IDLE;
      end
      if (cmd.scan_step) begin
         guard_in = guard_ff + 1'b1;
         guard_end_in = (guard_ff == SlotBits'(NumSlots - 1));
      end
      if (cmd.resp_exp) cnt_in = cnt_ff + 1'b1;
      if (cmd.resp_ack || cmd.resp_none || cmd.resp_exp) begin
         vld_in = 1'b1;
         last_in = cmd.res_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         vld_ff <= 1'b0;
         guard_ff <= '0;
         guard_end_ff <= 1'b0;
         stat_ff <= STAT_OK;
         last_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         vld_ff <= vld_in;
         guard_ff <= guard_in;
         guard_end_ff <= guard_end_in;
         stat_ff <= stat_in;
         last_ff <= last_in;
      end
   end

endmodule

[hw/rtl/stq_dpath.sv]
// ----------------------------------------------------------------------------
// stq_dpath: slot tables, linked list and result register
// Holds the per-slot expiry, tag and links, the head and tail pointers,
// the scan cursor, and the held result word with its last flag.
// ----------------------------------------------------------------------------
module stq_dpath (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [79:0]           req_tdata,
   input  logic [31:0]           req_tuser,
   input  logic                  rsp_fire,
   input  stq_pkg::stq_cmd_type  cmd,
   output stq_pkg::stq_stat_type sts,
   output logic [39:0]           rsp_tdata,
   output logic [3:0]            rsp_tuser,
   output logic                  rsp_tlast
);
   import stq_pkg::*;

   logic [NumSlots-1:0] act_ff, act_in;
   logic [TimeBits-1:0] exp_ff  [NumSlots];
   logic [TagBits-1:0]  tag_ff  [NumSlots];
   logic [LinkBits-1:0] nxt_ff  [NumSlots];
   logic [LinkBits-1:0] prv_ff  [NumSlots];
   logic [LinkBits-1:0] head_ff, tail_ff, cur_ff, prv_cur_ff;

   cmd_type             op_ff;
   logic [SlotBits-1:0] slot_ff;
   logic [TimeBits-1:0] t_ff, now_ff;
   logic [TagBits-1:0]  utag_ff;

   kind_type            r_kind_ff;
   status_type          r_stat_ff;
   logic [SlotBits-1:0] r_slot_ff;
   logic [TagBits-1:0]  r_tag_ff;
   logic                r_last_ff;

   logic [SlotBits-1:0] hs;
   logic [LinkBits-1:0] hn;
   logic [LinkBits-1:0] u_p, u_n;
   logic [SlotBits-1:0] us;

   assign hs = head_ff[SlotBits-1:0];
   assign hn = nxt_ff[hs];
   // unlink target: captured slot or head
   assign us  = cmd.pop_head ? hs : slot_ff;
   assign u_p = prv_ff[us];
   assign u_n = nxt_ff[us];

   // status toward the controller
   always_comb begin
      sts.cmd = op_ff;
      sts.in_range = 1'b1;
      sts.busy = act_ff[slot_ff];
      sts.scan_more = !cur_ff[SlotBits] && (exp_ff[cur_ff[SlotBits-1:0]] <= t_ff);
      sts.head_due = !head_ff[SlotBits] && (exp_ff[hs] <= now_ff);
      sts.next_due = !head_ff[SlotBits] && !hn[SlotBits] &&
                     (exp_ff[hn[SlotBits-1:0]] <= now_ff);
   end

   // active bits
   always_comb begin
      act_in = act_ff;
      if (cmd.set_active) act_in[slot_ff] = 1'b1;
      if (cmd.clr_active) act_in[slot_ff] = 1'b0;
      if (cmd.pop_head) act_in[hs] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= '0;
         head_ff <= LinkNil;
         tail_ff <= LinkNil;
      end else begin
         act_ff <= act_in;
         // unlink of a slot or of the head
         if (cmd.unlink || cmd.pop_head) begin
            if (u_p[SlotBits]) head_ff <= u_n;
            if (u_n[SlotBits]) tail_ff <= u_p;
         end
         // link before the cursor
         if (cmd.link) begin
            if (prv_cur_ff[SlotBits]) head_ff <= {1'b0, slot_ff};
            if (cur_ff[SlotBits]) tail_ff <= {1'b0, slot_ff};
         end
      end
   end

   // tables, cursor, captured word and result register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= cmd_type'(req_tdata[1:0]);
         slot_ff <= req_tdata[5:2];
         t_ff    <= req_tdata[37:6];
         utag_ff <= req_tdata[69:38];
         now_ff  <= req_tuser;
      end
      if (cmd.write_exp) exp_ff[slot_ff] <= t_ff;
      if (cmd.set_active) tag_ff[slot_ff] <= utag_ff;
      if (cmd.unlink || cmd.pop_head) begin
         if (!u_p[SlotBits]) nxt_ff[u_p[SlotBits-1:0]] <= u_n;
         if (!u_n[SlotBits]) prv_ff[u_n[SlotBits-1:0]] <= u_p;
      end
      if (cmd.scan_start) begin
         cur_ff <= head_ff;
         prv_cur_ff <= LinkNil;
      end
      if (cmd.unlink && head_ff == {1'b0, slot_ff}) cur_ff <= u_n;
      if (cmd.scan_step) begin
         prv_cur_ff <= cur_ff;
         cur_ff <= nxt_ff[cur_ff[SlotBits-1:0]];
      end
      if (cmd.link) begin
         prv_ff[slot_ff] <= prv_cur_ff;
         nxt_ff[slot_ff] <= cur_ff;
         if (!prv_cur_ff[SlotBits]) nxt_ff[prv_cur_ff[SlotBits-1:0]] <= {1'b0, slot_ff};
         if (!cur_ff[SlotBits]) prv_ff[cur_ff[SlotBits-1:0]] <= {1'b0, slot_ff};
      end
      if (cmd.resp_ack) begin
         r_kind_ff <= KIND_ACK;
         r_stat_ff <= cmd.stat;
         r_slot_ff <= slot_ff;
         r_tag_ff  <= '0;
      end
      if (cmd.resp_none) begin
         r_kind_ff <= KIND_NONE;
         r_stat_ff <= STAT_OK;
         r_slot_ff <= '0;
         r_tag_ff  <= '0;
      end
      if (cmd.resp_exp) begin
         r_kind_ff <= KIND_EXPIRED;
         r_stat_ff <= STAT_OK;
         r_slot_ff <= hs;
         r_tag_ff  <= tag_ff[hs];
      end
      if (cmd.resp_ack || cmd.resp_none || cmd.resp_exp) r_last_ff <= cmd.res_last;
      else if (cmd.res_last) r_last_ff <= 1'b1;
      else if (rsp_fire) r_last_ff <= 1'b0;
   end

   assign rsp_tdata = {2'b00, r_tag_ff, r_slot_ff, r_stat_ff};
   assign rsp_tuser = {2'b00, r_kind_ff};
   assign rsp_tlast = r_last_ff;

endmodule

[hw/rtl/sorted_timer_queue_top.sv]
// ----------------------------------------------------------------------------
// sorted_timer_queue_top: ascending sorted timer list of sixteen slots
//
//  channel | dir | tdata                               | tuser    | tlast
//  req     | in  | cmd, slot_id, expire_time, user_tag | now_time | -
//  rsp     | out | status, expired_slot, expired_tag   | kind     | last
//
// One command at a time. Add and adjust run a sorted scan that passes up to
// 15 list entries; delete and an empty tick need no scan; a tick that
// expires entries returns one result word per expired entry.
// Reset clears the active bits and empties the list.
// Each result word is held in an output register until rsp_tready; a stall
// holds the sequencer in its wait state.
// ----------------------------------------------------------------------------
module sorted_timer_queue_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,  // cmd, slot_id, expire_time, user_tag, zero pad
   input  logic [31:0] req_tuser,  // now_time
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // status, expired_slot, expired_tag, zero pad
   output logic [3:0]  rsp_tuser,  // kind, zero pad
   output logic        rsp_tlast   // last
);
   import stq_pkg::*;

   stq_cmd_type  cmd;
   stq_stat_type sts;

   stq_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .sts, .cmd
   );

   stq_dpath u_dpath (
      .clock, .reset, .req_tdata, .req_tuser,
      .rsp_fire(rsp_tvalid && rsp_tready),
      .cmd, .sts, .rsp_tdata, .rsp_tuser, .rsp_tlast
   );

endmodule

[hw/rtl/stq_checker.sv]
// ----------------------------------------------------------------------------
// stq_checker: port-level checks of the sorted timer queue
// Watches the handshakes and result fields seen at the top level.
// ----------------------------------------------------------------------------
module stq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [3:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import stq_pkg::*;

   // a stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed under stall");

   // no new command taken while a result waits
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("command accepted with result pending");

   // acknowledge and empty tick are single words
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[1:0] == KIND_ACK || rsp_tuser[1:0] == KIND_NONE)
      |-> rsp_tlast)
      else $error("single result word without last");

   // empty tick reports zero slot and tag
   a_none: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == KIND_NONE |-> rsp_tdata == '0)
      else $error("empty tick with nonzero payload");

endmodule

bind sorted_timer_queue_top stq_checker u_stq_checker (.*);
